[hdl/chi_pkg.sv]
// shared types, constants and helpers for the collimator hole index core
package chi_pkg;

   localparam int POS_BITS = 40;
   localparam int IDX_BITS = 21;
   localparam int DIV_BITS = 32;
   localparam int RSQ_BITS = 56;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 56;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int REQ_DATA_BITS = 2 * POS_BITS;
   localparam int RSP_FIELD_BITS = 1 + 2 * IDX_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SQUARE_MODE    = 3'd0,
      CSR_HALF_PITCH     = 3'd1,
      CSR_ROW_HEIGHT     = 3'd2,
      CSR_RADIUS_SQUARED = 3'd3,
      CSR_CELL_SIZE      = 3'd4,
      CSR_WALL_THICKNESS = 3'd5
   } csr_index_type;

   localparam logic [DIV_BITS-1:0] RST_HALF_PITCH     = 32'd14000000;
   localparam logic [DIV_BITS-1:0] RST_ROW_HEIGHT     = 32'd24248711;
   localparam logic [RSQ_BITS-1:0] RST_RADIUS_SQUARED = 56'd156250000000000;
   localparam logic [DIV_BITS-1:0] RST_CELL_SIZE      = 32'd99000000;
   localparam logic [DIV_BITS-1:0] RST_WALL_THICKNESS = 32'd16000000;

   // quotients and remainders of one position, handed from front to back
   typedef struct packed {
      logic                square;
      logic [POS_BITS-1:0] quo_x;
      logic [DIV_BITS-1:0] rem_x;
      logic [POS_BITS-1:0] quo_y;
      logic [DIV_BITS-1:0] rem_y;
   } cell_item_type;

   // a divisor of zero acts as one
   function automatic logic [DIV_BITS-1:0] nonzero(input logic [DIV_BITS-1:0] v);
      nonzero = (v == '0) ? DIV_BITS'(1) : v;
   endfunction

endpackage

[hdl/collimator_hole_index_core.sv]
// collimator hole index core: config registers, front, queue and back
// path of a position: 40 bit-per-stage divider stages, the queue, then 3 back stages
// throughput: one position per cycle unless the output stalls (dividers and back pipe)
// in square mode the cell division replaces the pitch and row divisions
// reset: synchronous, clears all pipe valid bits and queue, loads register defaults
module collimator_hole_index_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [chi_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // pos_x, pos_y
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [chi_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // open, hole_col, hole_row, zero pad
   input  logic                                csr_we,
   input  logic [chi_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [chi_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   localparam int P = chi_pkg::POS_BITS;
   localparam int I = chi_pkg::IDX_BITS;
   localparam int W = chi_pkg::DIV_BITS;

   logic          square_mode_ff;
   logic [W-1:0]  half_pitch_ff, row_height_ff, cell_size_ff, wall_thickness_ff;
   logic [chi_pkg::RSQ_BITS-1:0] radius_squared_ff;

   logic                    f_valid, q_ready, q_valid, b_pop;
   chi_pkg::cell_item_type  f_item, q_item;
   logic                    r_open;
   logic [I-1:0]            r_col, r_row;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         square_mode_ff    <= 1'b0;
         half_pitch_ff     <= chi_pkg::RST_HALF_PITCH;
         row_height_ff     <= chi_pkg::RST_ROW_HEIGHT;
         radius_squared_ff <= chi_pkg::RST_RADIUS_SQUARED;
         cell_size_ff      <= chi_pkg::RST_CELL_SIZE;
         wall_thickness_ff <= chi_pkg::RST_WALL_THICKNESS;
      end else if (csr_we) begin
         case (chi_pkg::csr_index_type'(csr_index))
            chi_pkg::CSR_SQUARE_MODE:    square_mode_ff    <= csr_wdata[0];
            chi_pkg::CSR_HALF_PITCH:     half_pitch_ff     <= csr_wdata[W-1:0];
            chi_pkg::CSR_ROW_HEIGHT:     row_height_ff     <= csr_wdata[W-1:0];
            chi_pkg::CSR_RADIUS_SQUARED: radius_squared_ff <= csr_wdata;
            chi_pkg::CSR_CELL_SIZE:      cell_size_ff      <= csr_wdata[W-1:0];
            chi_pkg::CSR_WALL_THICKNESS: wall_thickness_ff <= csr_wdata[W-1:0];
            default: ;
         endcase
      end
   end

   chi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .pos_x       (req_tdata[P-1:0]),
      .pos_y       (req_tdata[2*P-1:P]),
      .square_mode (square_mode_ff),
      .half_pitch  (half_pitch_ff),
      .row_height  (row_height_ff),
      .cell_size   (cell_size_ff),
      .out_valid   (f_valid),
      .out_ready   (q_ready),
      .out_item    (f_item)
   );

   chi_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_item  (f_item),
      .push_ready (q_ready),
      .pop        (b_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item)
   );

   chi_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_valid),
      .in_pop         (b_pop),
      .in_item        (q_item),
      .half_pitch     (half_pitch_ff),
      .row_height     (row_height_ff),
      .radius_squared (radius_squared_ff),
      .wall_thickness (wall_thickness_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_open       (r_open),
      .out_col        (r_col),
      .out_row        (r_row)
   );

   assign rsp_tdata = chi_pkg::RSP_DATA_BITS'({r_row, r_col, r_open});

   // a closed position reports zero indices
   a_closed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !r_open |-> r_col == '0 && r_row == '0)
      else $error("closed result with nonzero indices");

   // the front never hands an item to a full queue without holding it
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      f_valid && !q_ready |-> !req_tready)
      else $error("front advanced into a full queue");

   // nothing is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

[hdl/chi_div.sv]
// pipelined restoring divider, one quotient bit per stage
module chi_div (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [chi_pkg::POS_BITS-1:0]   dividend,
   input  logic [chi_pkg::DIV_BITS-1:0]   divisor,
   output logic [chi_pkg::POS_BITS-1:0]   quotient,
   output logic [chi_pkg::DIV_BITS-1:0]   remainder
);
   localparam int N = chi_pkg::POS_BITS;
   localparam int W = chi_pkg::DIV_BITS;

   logic [W-1:0] rem_ff [N];
   logic [N-1:0] num_ff [N];
   logic [N-1:0] quo_ff [N];

   // one stage per quotient bit, most significant first
   for (genvar g = 0; g < N; g++) begin : g_stage
      logic [W-1:0] rem_src;
      logic [N-1:0] num_src;
      logic [N-1:0] quo_src;
      logic [W:0]   trial;
      logic         fits;
      logic [W-1:0] rem_in;
      logic [N-1:0] quo_in;

      if (g == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = dividend;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign num_src = num_ff[g-1];
         assign quo_src = quo_ff[g-1];
      end

      assign trial  = {rem_src, num_src[N-1]};
      assign fits   = trial >= {1'b0, divisor};
      assign rem_in = fits ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
      assign quo_in = {quo_src[N-2:0], fits};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            num_ff[g] <= {num_src[N-2:0], 1'b0};
         end
      end
   end

   assign quotient  = quo_ff[N-1];
   assign remainder = rem_ff[N-1];
endmodule

[hdl/chi_front.sv]
// front end: accepts positions and splits them into cell indices and offsets
module chi_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [chi_pkg::POS_BITS-1:0]   pos_x,
   input  logic [chi_pkg::POS_BITS-1:0]   pos_y,
   input  logic                           square_mode,
   input  logic [chi_pkg::DIV_BITS-1:0]   half_pitch,
   input  logic [chi_pkg::DIV_BITS-1:0]   row_height,
   input  logic [chi_pkg::DIV_BITS-1:0]   cell_size,
   output logic                           out_valid,
   input  logic                           out_ready,
   output chi_pkg::cell_item_type         out_item
);
   localparam int N = chi_pkg::POS_BITS;

   logic [N-1:0]                  vld_ff, vld_in;
   logic [N-1:0]                  mode_ff, mode_in;
   logic                          adv;
   logic [chi_pkg::DIV_BITS-1:0]  div_x, div_y;

   // the whole pipe moves unless its last item is blocked at the queue
   assign adv      = !(vld_ff[N-1] && !out_ready);
   assign in_ready = adv;

   // divisors by mode
   assign div_x = square_mode ? chi_pkg::nonzero(cell_size) : chi_pkg::nonzero(half_pitch);
   assign div_y = square_mode ? chi_pkg::nonzero(cell_size) : chi_pkg::nonzero(row_height);

   assign vld_in  = {vld_ff[N-2:0], in_valid};
   assign mode_in = {mode_ff[N-2:0], square_mode};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff <= mode_in;
      end
   end

   chi_div u_div_x (
      .clock     (clock),
      .adv       (adv),
      .dividend  (pos_x),
      .divisor   (div_x),
      .quotient  (out_item.quo_x),
      .remainder (out_item.rem_x)
   );

   chi_div u_div_y (
      .clock     (clock),
      .adv       (adv),
      .dividend  (pos_y),
      .divisor   (div_y),
      .quotient  (out_item.quo_y),
      .remainder (out_item.rem_y)
   );

   assign out_item.square = mode_ff[N-1];
   assign out_valid       = vld_ff[N-1];
endmodule

[hdl/chi_fifo.sv]
// short queue between front and back
module chi_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  chi_pkg::cell_item_type  push_item,
   output logic                    push_ready,
   input  logic                    pop,
   output logic                    pop_valid,
   output chi_pkg::cell_item_type  pop_item
);
   localparam int AW = chi_pkg::FIFO_AW;

   chi_pkg::cell_item_type mem [chi_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = cnt_ff != (AW+1)'(chi_pkg::FIFO_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = mem[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = do_push ? AW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_item;
      end
   end
endmodule

[hdl/chi_back.sv]
// back end: distance tests against candidate centres and result register
module chi_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_pop,
   input  chi_pkg::cell_item_type         in_item,
   input  logic [chi_pkg::DIV_BITS-1:0]   half_pitch,
   input  logic [chi_pkg::DIV_BITS-1:0]   row_height,
   input  logic [chi_pkg::RSQ_BITS-1:0]   radius_squared,
   input  logic [chi_pkg::DIV_BITS-1:0]   wall_thickness,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_open,
   output logic [chi_pkg::IDX_BITS-1:0]   out_col,
   output logic [chi_pkg::IDX_BITS-1:0]   out_row
);
   localparam int W = chi_pkg::DIV_BITS;
   localparam int I = chi_pkg::IDX_BITS;

   logic          adv;
   logic [W-1:0]  hp, rh;
   logic          odd;
   logic [W-1:0]  dx0_in, dx1_in, dy0_in, dy1_in;
   logic [I-1:0]  col0_in, col1_in, row0_in, row1_in;
   logic          sq_open_in;

   logic          v1_ff, v2_ff, vo_ff;
   logic          sq1_ff, sq2_ff, sqo1_ff, sqo2_ff;
   logic [W-1:0]  dx0_ff, dx1_ff, dy0_ff, dy1_ff;
   logic [I-1:0]  col0_ff, col1_ff, row0_ff, row1_ff;
   logic [I-1:0]  col0b_ff, col1b_ff, row0b_ff, row1b_ff;
   logic [2*W-1:0] px0_ff, px1_ff, py0_ff, py1_ff;
   logic [2*W:0]  sum0, sum1;
   logic          hit0, hit1;
   logic          open_in, open_ff;
   logic [I-1:0]  col_in, row_in, col_ff, row_ff;

   assign adv    = !vo_ff || out_ready;
   assign in_pop = adv;
   assign hp     = chi_pkg::nonzero(half_pitch);
   assign rh     = chi_pkg::nonzero(row_height);

   // candidate offsets: the centre of column ci+1 lies hp minus the offset away
   // square mode keeps the plain cell indices in the first candidate
   always_comb begin
      odd        = !in_item.square && (in_item.quo_x[0] ^ in_item.quo_y[0]);
      dx0_in     = odd ? W'(hp - in_item.rem_x) : in_item.rem_x;
      dx1_in     = odd ? in_item.rem_x : W'(hp - in_item.rem_x);
      dy0_in     = in_item.rem_y;
      dy1_in     = W'(rh - in_item.rem_y);
      col0_in    = odd ? I'(in_item.quo_x + 1'b1) : in_item.quo_x[I-1:0];
      col1_in    = odd ? in_item.quo_x[I-1:0] : I'(in_item.quo_x + 1'b1);
      row0_in    = in_item.quo_y[I-1:0];
      row1_in    = I'(in_item.quo_y + 1'b1);
      sq_open_in = (in_item.rem_x > wall_thickness) && (in_item.rem_y > wall_thickness);
   end

   // stage one: offsets and indices
   always_ff @(posedge clock) begin
      if (adv) begin
         sq1_ff  <= in_item.square;
         sqo1_ff <= sq_open_in;
         dx0_ff  <= dx0_in;
         dx1_ff  <= dx1_in;
         dy0_ff  <= dy0_in;
         dy1_ff  <= dy1_in;
         col0_ff <= col0_in;
         col1_ff <= col1_in;
         row0_ff <= row0_in;
         row1_ff <= row1_in;
      end
   end

   // stage two: squares
   always_ff @(posedge clock) begin
      if (adv) begin
         sq2_ff   <= sq1_ff;
         sqo2_ff  <= sqo1_ff;
         px0_ff   <= dx0_ff * dx0_ff;
         px1_ff   <= dx1_ff * dx1_ff;
         py0_ff   <= dy0_ff * dy0_ff;
         py1_ff   <= dy1_ff * dy1_ff;
         col0b_ff <= col0_ff;
         col1b_ff <= col1_ff;
         row0b_ff <= row0_ff;
         row1b_ff <= row1_ff;
      end
   end

   // stage three: strict inside test, first candidate wins; square mode takes the wall test
   always_comb begin
      sum0 = {1'b0, px0_ff} + {1'b0, py0_ff};
      sum1 = {1'b0, px1_ff} + {1'b0, py1_ff};
      hit0 = sum0 < (2*W+1)'(radius_squared);
      hit1 = sum1 < (2*W+1)'(radius_squared);
      priority if (sq2_ff) begin
         open_in = sqo2_ff;
         col_in  = sqo2_ff ? col0b_ff : '0;
         row_in  = sqo2_ff ? row0b_ff : '0;
      end else if (hit0) begin
         open_in = 1'b1;
         col_in  = col0b_ff;
         row_in  = row0b_ff;
      end else if (hit1) begin
         open_in = 1'b1;
         col_in  = col1b_ff;
         row_in  = row1b_ff;
      end else begin
         open_in = 1'b0;
         col_in  = '0;
         row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         open_ff <= open_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   // valid bits of the back pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         vo_ff <= v2_ff;
      end
   end

   assign out_valid = vo_ff;
   assign out_open  = open_ff;
   assign out_col   = col_ff;
   assign out_row   = row_ff;
endmodule

[bench/collimator_hole_index_core_tb.sv]
// testbench for the collimator hole index core: scoreboard class, stimulus and checking
`timescale 1ns / 100ps

// expected outcome of one position lookup
typedef struct {
   bit                         is_open;
   bit [chi_pkg::IDX_BITS-1:0] col;
   bit [chi_pkg::IDX_BITS-1:0] row;
} hole_result_type;

// mirror of the hole lookup with its own register copy and pending results
class hole_scoreboard;
   bit                         square_mode;
   longint unsigned            half_pitch;
   longint unsigned            row_height;
   longint unsigned            radius_squared;
   longint unsigned            cell_size;
   longint unsigned            wall_thickness;
   hole_result_type            pending_holes[$];
   int                         mismatches;

   function new();
      square_mode    = 1'b0;
      half_pitch     = chi_pkg::RST_HALF_PITCH;
      row_height     = chi_pkg::RST_ROW_HEIGHT;
      radius_squared = chi_pkg::RST_RADIUS_SQUARED;
      cell_size      = chi_pkg::RST_CELL_SIZE;
      wall_thickness = chi_pkg::RST_WALL_THICKNESS;
      mismatches     = 0;
   endfunction

   function void set_reg(chi_pkg::csr_index_type idx, longint unsigned value);
      case (idx)
         chi_pkg::CSR_SQUARE_MODE:    square_mode    = value[0];
         chi_pkg::CSR_HALF_PITCH:     half_pitch     = value & 64'hFFFF_FFFF;
         chi_pkg::CSR_ROW_HEIGHT:     row_height     = value & 64'hFFFF_FFFF;
         chi_pkg::CSR_RADIUS_SQUARED: radius_squared = value & 64'hFF_FFFF_FFFF_FFFF;
         chi_pkg::CSR_CELL_SIZE:      cell_size      = value & 64'hFFFF_FFFF;
         chi_pkg::CSR_WALL_THICKNESS: wall_thickness = value & 64'hFFFF_FFFF;
         default: ;
      endcase
   endfunction

   // strictly inside the circle around one hole centre
   function bit in_circle(longint unsigned x, longint unsigned y,
                          longint unsigned cx, longint unsigned cy);
      longint unsigned dx, dy, dx2;
      dx = (x >= cx) ? x - cx : cx - x;
      dy = (y >= cy) ? y - cy : cy - y;
      if (dx >= 64'h1_0000_0000 || dy >= 64'h1_0000_0000) return 1'b0;
      dx2 = dx * dx;
      if (dx2 >= radius_squared) return 1'b0;
      return (dy * dy) < (radius_squared - dx2);
   endfunction

   function hole_result_type locate_hole(longint unsigned x, longint unsigned y);
      hole_result_type res;
      longint unsigned hp, rh, cs, ci, ri, c0, r0, c1, r1, colv, rowv;
      bit              hit;
      hit  = 1'b0;
      colv = 0;
      rowv = 0;
      if (square_mode) begin
         cs = (cell_size == 0) ? 1 : cell_size;
         ci = x / cs;
         ri = y / cs;
         if ((x - ci * cs) > wall_thickness && (y - ri * cs) > wall_thickness) begin
            hit = 1'b1; colv = ci; rowv = ri;
         end
      end else begin
         hp = (half_pitch == 0) ? 1 : half_pitch;
         rh = (row_height == 0) ? 1 : row_height;
         ri = y / rh;
         ci = x / hp;
         // centres sit where column plus row is even
         if (((ri + ci) & 1) == 0) begin
            c0 = ci;     r0 = ri; c1 = ci + 1; r1 = ri + 1;
         end else begin
            c0 = ci + 1; r0 = ri; c1 = ci;     r1 = ri + 1;
         end
         if (in_circle(x, y, c0 * hp, r0 * rh)) begin
            hit = 1'b1; colv = c0; rowv = r0;
         end else if (in_circle(x, y, c1 * hp, r1 * rh)) begin
            hit = 1'b1; colv = c1; rowv = r1;
         end
      end
      res.is_open = hit;
      res.col     = colv[chi_pkg::IDX_BITS-1:0];
      res.row     = rowv[chi_pkg::IDX_BITS-1:0];
      return res;
   endfunction

   function void note_position(longint unsigned x, longint unsigned y);
      pending_holes.push_back(locate_hole(x, y));
   endfunction

   function void check_result(bit [chi_pkg::RSP_DATA_BITS-1:0] data);
      hole_result_type exp_res;
      bit              got_open;
      bit [chi_pkg::IDX_BITS-1:0] got_col, got_row;
      got_open = data[0];
      got_col  = data[chi_pkg::IDX_BITS:1];
      got_row  = data[2*chi_pkg::IDX_BITS:chi_pkg::IDX_BITS+1];
      if (pending_holes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result open=%0d col=%0d row=%0d", got_open, got_col, got_row);
         return;
      end
      exp_res = pending_holes.pop_front();
      if (got_open !== exp_res.is_open || got_col !== exp_res.col ||
          got_row !== exp_res.row) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected open=%0d col=%0d row=%0d, got open=%0d col=%0d row=%0d",
                     exp_res.is_open, exp_res.col, exp_res.row, got_open, got_col, got_row);
      end
   endfunction
endclass

module collimator_hole_index_core_tb;

   localparam longint unsigned POS_MAX = (64'd1 << chi_pkg::POS_BITS) - 1;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [chi_pkg::REQ_DATA_BITS-1:0]   req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [chi_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                                csr_we = 1'b0;
   logic [chi_pkg::CSR_IDX_BITS-1:0]    csr_index = '0;
   logic [chi_pkg::CSR_DATA_BITS-1:0]   csr_wdata = '0;

   hole_scoreboard sb = new();
   int             burst_left = 0;
   int             accepted_total = 0;
   bit             timed_out = 1'b0;

   collimator_hole_index_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result transfers go to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver stall pattern, with one long hold-off once traffic is flowing
   initial begin : receiver
      int  mode, left, hold;
      bit  held;
      held = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (!held && accepted_total >= 400) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            for (hold = 0; hold < 400; hold++) @(posedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 96);
         end
         left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            2:       rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic write_csr(chi_pkg::csr_index_type idx, longint unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[chi_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   // one position transfer, sent in bursts with random gaps
   task automatic send_position(longint unsigned x, longint unsigned y);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y[chi_pkg::POS_BITS-1:0], x[chi_pkg::POS_BITS-1:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_position(x & POS_MAX, y & POS_MAX);
      burst_left--;
      accepted_total++;
   endtask

   // let every pending result arrive, then the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending_holes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic longint unsigned rand_pos();
      return {$urandom, $urandom} & POS_MAX;
   endfunction

   // coordinate near the lattice: a multiple of the step plus an offset within it
   function automatic longint unsigned lattice_coord(longint unsigned step);
      longint unsigned s, kmax, v;
      s = (step == 0) ? 1 : step;
      kmax = POS_MAX / s;
      if (kmax > 2) kmax = kmax - 2;
      if (kmax > 500) kmax = 500;
      v = longint'($urandom_range(0, int'(kmax))) * s + ($urandom % (s + 1));
      return v & POS_MAX;
   endfunction

   task automatic random_positions(int count);
      longint unsigned sx, sy;
      for (int n = 0; n < count; n++) begin
         sx = sb.square_mode ? sb.cell_size : sb.half_pitch;
         sy = sb.square_mode ? sb.cell_size : sb.row_height;
         case ($urandom_range(0, 7))
            0:       send_position(rand_pos(), rand_pos());
            1:       send_position(rand_pos(), lattice_coord(sy));
            2:       send_position(POS_MAX - $urandom_range(0, 3), lattice_coord(sy));
            default: send_position(lattice_coord(sx), lattice_coord(sy));
         endcase
      end
   endtask

   task automatic set_hex(longint unsigned hp, longint unsigned rh, longint unsigned rsq);
      write_csr(chi_pkg::CSR_SQUARE_MODE, 0);
      write_csr(chi_pkg::CSR_HALF_PITCH, hp);
      write_csr(chi_pkg::CSR_ROW_HEIGHT, rh);
      write_csr(chi_pkg::CSR_RADIUS_SQUARED, rsq);
   endtask

   task automatic set_square(longint unsigned cs, longint unsigned wall);
      write_csr(chi_pkg::CSR_SQUARE_MODE, 1);
      write_csr(chi_pkg::CSR_CELL_SIZE, cs);
      write_csr(chi_pkg::CSR_WALL_THICKNESS, wall);
   endtask

   initial begin : limit
      #4ms;
      timed_out = 1'b1;
      $display("** collimator_hole_index_core: FAILED **");
      $finish;
   end

   initial begin : main
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, all registers written once
      set_hex(chi_pkg::RST_HALF_PITCH, chi_pkg::RST_ROW_HEIGHT, chi_pkg::RST_RADIUS_SQUARED);
      write_csr(chi_pkg::CSR_CELL_SIZE, chi_pkg::RST_CELL_SIZE);
      write_csr(chi_pkg::CSR_WALL_THICKNESS, chi_pkg::RST_WALL_THICKNESS);
      send_position(0, 0);
      send_position(POS_MAX, POS_MAX);
      send_position(0, POS_MAX);
      send_position(POS_MAX, 0);
      // on the rim of the centre at column 2, row 2: closed, then just inside
      send_position(28000000 + 12500000, 48497422);
      send_position(28000000 + 12499999, 48497422);
      send_position(14000000, 24248711);
      // first candidate misses; second (next row) misses, then hits
      send_position(14000000 + 100, 48497422 - 1000);
      send_position(14000000 + 13000000, 24248711 + 23000000);
      send_position(7000000, 12000000);
      random_positions(150);
      drain();

      // small hex pitch
      set_hex(1000000, 1732051, 490000000000);
      random_positions(170);
      drain();

      // zero divisors act as one, indexes wrap
      set_hex(0, 0, 2);
      send_position(POS_MAX, POS_MAX - 1);
      send_position(5, 7);
      random_positions(150);
      drain();

      // widest pitch and radius
      set_hex(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFF_FFFF_FFFF_FFFF);
      send_position(64'hFFFF_FFFF, 64'hFFFF_FFFF);
      send_position(64'h1_FFFF_FFFE, 0);
      random_positions(150);
      drain();

      // zero radius never opens
      set_hex(chi_pkg::RST_HALF_PITCH, chi_pkg::RST_ROW_HEIGHT, 0);
      send_position(chi_pkg::RST_HALF_PITCH, chi_pkg::RST_ROW_HEIGHT);
      random_positions(120);
      drain();

      // square pores at reset sizes, remainders at and just above the wall
      set_square(chi_pkg::RST_CELL_SIZE, chi_pkg::RST_WALL_THICKNESS);
      send_position(99000000 + 16000000, 16000001);
      send_position(99000000 + 16000001, 16000001);
      send_position(16000001, 98999999);
      send_position(98999999, 16000000);
      random_positions(180);
      drain();

      // thin walls, then zero cell
      set_square(1000000, 0);
      random_positions(170);
      drain();
      set_square(0, 0);
      random_positions(60);
      drain();

      // widest cell, wall just below it, then wall at maximum
      set_square(64'hFFFF_FFFF, 64'hFFFF_FFFE);
      send_position(64'hFFFF_FFFF, 64'hFFFF_FFFF);
      random_positions(120);
      drain();
      write_csr(chi_pkg::CSR_WALL_THICKNESS, 64'hFFFF_FFFF);
      random_positions(100);
      drain();

      if (sb.mismatches == 0 && !timed_out)
         $display("** collimator_hole_index_core: PASSED **");
      else
         $display("** collimator_hole_index_core: FAILED **");
      $finish;
   end

endmodule
